// ===== hw/rtl/utf8v_pkg.sv =====
`timescale 1ns / 1ps

package utf8v_pkg;

    localparam int POSITION_BITS = 32;
    localparam int DATA_BITS     = 8;
    localparam int POS_OUT_BITS  = 32;
    localparam int RESULT_BITS   = 48;

    localparam logic [7:0] F_CONT  = 8'h01;
    localparam logic [7:0] F_MULT  = 8'h02;
    localparam logic [7:0] F_OL2   = 8'h04;
    localparam logic [7:0] F_OL3   = 8'h08;
    localparam logic [7:0] F_OL4   = 8'h10;
    localparam logic [7:0] F_SUR   = 8'h20;
    localparam logic [7:0] F_RANGE = 8'h40;
    localparam logic [7:0] F_INV   = 8'h80;

    localparam logic [7:0] HI_TAB [16] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        F_CONT, F_CONT, F_CONT, F_CONT,
        F_MULT | F_OL2,
        F_MULT,
        F_MULT | F_OL3 | F_SUR,
        F_MULT | F_OL4 | F_RANGE | F_INV
    };

    localparam logic [7:0] LO_TAB [16] = '{
        F_CONT | F_MULT | F_OL2 | F_OL3 | F_OL4,
        F_CONT | F_MULT | F_OL2,
        F_CONT | F_MULT,
        F_CONT | F_MULT,
        F_CONT | F_MULT | F_RANGE,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_SUR | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV
    };

    localparam logic [7:0] NX_TAB [16] = '{
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_OL2 | F_OL3 | F_OL4 | F_INV,
        F_CONT | F_OL2 | F_OL3 | F_RANGE | F_INV,
        F_CONT | F_OL2 | F_OL3 | F_SUR | F_RANGE | F_INV,
        F_CONT | F_OL2 | F_OL3 | F_SUR | F_RANGE | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV,
        F_CONT | F_MULT | F_INV
    };

    // change of the pending count per high nibble, modulo 4
    localparam logic [1:0] COUNT_TAB [16] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3
    };

    function automatic logic [7:0] judge_flags(input logic [7:0] b, input logic [3:0] next_hi,
                                               input logic [1:0] pending);
        logic [7:0] v;
        begin
            v = HI_TAB[b[7:4]] & LO_TAB[b[3:0]] & NX_TAB[next_hi];
            v[0] = v[0] ^ (pending != 2'd0);
            return v;
        end
    endfunction

    function automatic logic [1:0] count_step(input logic [7:0] b, input logic [1:0] pending);
        return pending + COUNT_TAB[b[7:4]];
    endfunction

endpackage

// ===== hw/rtl/utf8_stream_validator.sv =====
`timescale 1ns / 1ps

// UTF-8 stream validator. Takes one byte per transfer on the s_ side, with s_tlast on
// the final byte of a stream, and sustains one byte per clock. Each byte is judged
// against the high nibble of the byte after it with three 16-entry nibble tables and a
// two-bit count of owed continuation bytes; the final byte is judged against 0x00. The
// result is offered on the m_ side once the final byte has passed from the input
// register into the result register. It carries the flags and index of the first
// failing byte, or the incomplete flag with the index of the final byte, or all zeros
// for a valid stream. The next byte then starts a new stream at index 0. The rate is
// one byte per clock because all judging is combinational between the input register
// and the result register; s_tready drops only while the final byte of a stream sits
// in the input register and the previous result still waits on m_tready.
module utf8_stream_validator #(
    parameter int POSITION_BITS = utf8v_pkg::POSITION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [7:0] error_flags, [39:8] error_position, [40] incomplete
);

    localparam int ExtBits = (POSITION_BITS > utf8v_pkg::POS_OUT_BITS) ?
                             POSITION_BITS : utf8v_pkg::POS_OUT_BITS;

    logic                     in_valid_reg, in_valid_next;
    logic [7:0]               in_byte_reg, in_byte_next;
    logic                     in_last_reg, in_last_next;

    logic [7:0]               held_byte_reg, held_byte_next;
    logic                     held_valid_reg, held_valid_next;
    logic [1:0]               pend_reg, pend_next;
    logic                     err_reg, err_next;
    logic [7:0]               err_flags_reg, err_flags_next;
    logic [POSITION_BITS-1:0] err_index_reg, err_index_next;
    logic [POSITION_BITS-1:0] byte_index_reg, byte_index_next;

    logic                     out_valid_reg, out_valid_next;
    logic [47:0]              out_data_reg, out_data_next;

    logic                     advance;
    logic                     fire;
    logic [7:0]               flags_a, flags_b;
    logic [1:0]               pend_a, pend_b;
    logic                     lat_a, lat_b;
    logic [7:0]               eflags_a, eflags_b;
    logic [POSITION_BITS-1:0] eidx_a, eidx_b;
    logic [POSITION_BITS-1:0] pos_sel;
    logic [ExtBits-1:0]       pos_ext;
    logic [7:0]               res_flags;
    logic                     res_incomplete;

    assign advance  = !(in_last_reg && out_valid_reg && !m_tready);
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // judge the held byte, then the incoming byte against a stand-in 0x00
    always_comb
    begin
        pend_a  = pend_reg;
        flags_a = 8'h00;
        if (held_valid_reg)
        begin
            flags_a = utf8v_pkg::judge_flags(held_byte_reg, in_byte_reg[7:4], pend_reg);
            pend_a  = utf8v_pkg::count_step(held_byte_reg, pend_reg);
        end
        flags_b = utf8v_pkg::judge_flags(in_byte_reg, 4'h0, pend_a);
        pend_b  = utf8v_pkg::count_step(in_byte_reg, pend_a);

        lat_a    = err_reg || (flags_a != 8'h00);
        eflags_a = err_reg ? err_flags_reg : flags_a;
        eidx_a   = err_reg ? err_index_reg : (byte_index_reg - POSITION_BITS'(1));

        lat_b    = lat_a || (flags_b != 8'h00);
        eflags_b = lat_a ? eflags_a : flags_b;
        eidx_b   = lat_a ? eidx_a : byte_index_reg;

        res_flags      = 8'h00;
        res_incomplete = 1'b0;
        pos_sel        = '0;
        if (lat_b)
        begin
            res_flags = eflags_b;
            pos_sel   = eidx_b;
        end
        else if (pend_b != 2'd0)
        begin
            res_incomplete = 1'b1;
            pos_sel        = byte_index_reg;
        end
        pos_ext = ExtBits'(pos_sel);
    end

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_byte_next    = in_byte_reg;
        in_last_next    = in_last_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        pend_next       = pend_reg;
        err_next        = err_reg;
        err_flags_next  = err_flags_reg;
        err_index_next  = err_index_reg;
        byte_index_next = byte_index_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;

        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_last_next  = s_tlast;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        if (fire)
        begin
            if (in_last_reg)
            begin
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
                pend_next       = 2'd0;
                err_next        = 1'b0;
                err_flags_next  = 8'h00;
                err_index_next  = '0;
                byte_index_next = '0;
                out_valid_next  = 1'b1;
                out_data_next   = {7'b0, res_incomplete,
                                   pos_ext[utf8v_pkg::POS_OUT_BITS-1:0], res_flags};
            end
            else
            begin
                held_byte_next  = in_byte_reg;
                held_valid_next = 1'b1;
                pend_next       = pend_a;
                err_next        = lat_a;
                err_flags_next  = eflags_a;
                err_index_next  = eidx_a;
                byte_index_next = byte_index_reg + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_byte_reg    <= 8'h00;
            in_last_reg    <= 1'b0;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            pend_reg       <= 2'd0;
            err_reg        <= 1'b0;
            err_flags_reg  <= 8'h00;
            err_index_reg  <= '0;
            byte_index_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            in_byte_reg    <= in_byte_next;
            in_last_reg    <= in_last_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            pend_reg       <= pend_next;
            err_reg        <= err_next;
            err_flags_reg  <= err_flags_next;
            err_index_reg  <= err_index_next;
            byte_index_reg <= byte_index_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

endmodule

// ===== hw/rtl/utf8v_checker.sv =====
`timescale 1ns / 1ps

module utf8v_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // a result transfer stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transfer");

    // a fresh result follows a final-byte transfer through the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a final byte");

    // incomplete only when no error flag is set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |-> m_tdata[7:0] == 8'h00)
        else $error("incomplete together with error flags");

    // a clean stream reports position zero and no spare bits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] == 8'h00 && !m_tdata[40]
        |-> m_tdata[39:8] == 32'h0 && m_tdata[47:41] == 7'h0)
        else $error("valid stream with nonzero position");

endmodule

bind utf8_stream_validator utf8v_checker u_checker (.*);

// ===== sim/utf8_stream_validator_test.sv =====
`timescale 1ns / 1ps

module utf8_stream_validator_test;

    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed
    {
        logic [7:0]  flags;
        logic [31:0] pos;
        logic        incomplete;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    utf8_stream_validator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    byte_item_t  stim_q[$];
    logic [7:0]  frame[$];
    verdict_t    owed_verdicts[$];

    // validator state mirrored here
    logic [7:0]  held_byte = 8'h00;
    logic        held_valid = 1'b0;
    logic [1:0]  owed_conts = 2'd0;
    logic        fault_seen = 1'b0;
    logic [7:0]  fault_flags = 8'h00;
    logic [31:0] fault_pos = 32'd0;
    logic [31:0] next_pos = 32'd0;

    logic        in_fire = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          long_hold = 0;
    bit          hold_done = 1'b0;
    int          bytes_taken = 0;
    int          streams_seen = 0;
    int          error_streams = 0;
    int          incomplete_streams = 0;
    int          mismatches = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] lead_mask(input logic [3:0] n);
        if (n < 4'h8)
            return 8'h00;
        else if (n < 4'hC)
            return utf8v_pkg::F_CONT;
        else if (n == 4'hC)
            return utf8v_pkg::F_MULT | utf8v_pkg::F_OL2;
        else if (n == 4'hD)
            return utf8v_pkg::F_MULT;
        else if (n == 4'hE)
            return utf8v_pkg::F_MULT | utf8v_pkg::F_OL3 | utf8v_pkg::F_SUR;
        else
            return utf8v_pkg::F_MULT | utf8v_pkg::F_OL4 | utf8v_pkg::F_RANGE
                   | utf8v_pkg::F_INV;
    endfunction

    function automatic logic [7:0] tail_mask(input logic [3:0] n);
        case (n)
            4'h0:       return utf8v_pkg::F_CONT | utf8v_pkg::F_MULT | utf8v_pkg::F_OL2
                               | utf8v_pkg::F_OL3 | utf8v_pkg::F_OL4;
            4'h1:       return utf8v_pkg::F_CONT | utf8v_pkg::F_MULT | utf8v_pkg::F_OL2;
            4'h2, 4'h3: return utf8v_pkg::F_CONT | utf8v_pkg::F_MULT;
            4'h4:       return utf8v_pkg::F_CONT | utf8v_pkg::F_MULT | utf8v_pkg::F_RANGE;
            4'hD:       return utf8v_pkg::F_CONT | utf8v_pkg::F_MULT | utf8v_pkg::F_SUR
                               | utf8v_pkg::F_INV;
            default:    return utf8v_pkg::F_CONT | utf8v_pkg::F_MULT | utf8v_pkg::F_INV;
        endcase
    endfunction

    function automatic logic [7:0] follow_mask(input logic [3:0] n);
        case (n)
            4'h8:       return utf8v_pkg::F_CONT | utf8v_pkg::F_OL2 | utf8v_pkg::F_OL3
                               | utf8v_pkg::F_OL4 | utf8v_pkg::F_INV;
            4'h9:       return utf8v_pkg::F_CONT | utf8v_pkg::F_OL2 | utf8v_pkg::F_OL3
                               | utf8v_pkg::F_RANGE | utf8v_pkg::F_INV;
            4'hA, 4'hB: return utf8v_pkg::F_CONT | utf8v_pkg::F_OL2 | utf8v_pkg::F_OL3
                               | utf8v_pkg::F_SUR | utf8v_pkg::F_RANGE | utf8v_pkg::F_INV;
            default:    return utf8v_pkg::F_CONT | utf8v_pkg::F_MULT | utf8v_pkg::F_INV;
        endcase
    endfunction

    // owed continuation change per lead nibble, modulo 4
    function automatic logic [1:0] owed_delta(input logic [3:0] n);
        if (n < 4'h8)
            return 2'd0;
        else if (n < 4'hC)
            return 2'd3;
        else if (n < 4'hE)
            return 2'd1;
        else if (n == 4'hE)
            return 2'd2;
        else
            return 2'd3;
    endfunction

    task automatic grade_byte(input logic [7:0] b, input logic [3:0] next_hi,
                              input logic [31:0] at);
        logic [7:0] f;
        f = lead_mask(b[7:4]) & tail_mask(b[3:0]) & follow_mask(next_hi);
        f[0] = f[0] ^ (owed_conts != 2'd0);
        owed_conts = owed_conts + owed_delta(b[7:4]);
        if (f != 8'h00 && !fault_seen)
        begin
            fault_seen = 1'b1;
            fault_flags = f;
            fault_pos = at;
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        if (held_valid)
            grade_byte(held_byte, b[7:4], next_pos - 32'd1);
        if (!last)
        begin
            held_byte = b;
            held_valid = 1'b1;
            next_pos = next_pos + 32'd1;
        end
        else
        begin
            grade_byte(b, 4'h0, next_pos);
            v = '0;
            if (fault_seen)
            begin
                v.flags = fault_flags;
                v.pos = fault_pos;
            end
            else if (owed_conts != 2'd0)
            begin
                v.pos = next_pos;
                v.incomplete = 1'b1;
            end
            owed_verdicts.push_back(v);
            held_byte = 8'h00;
            held_valid = 1'b0;
            owed_conts = 2'd0;
            fault_seen = 1'b0;
            fault_flags = 8'h00;
            fault_pos = 32'd0;
            next_pos = 32'd0;
        end
    endtask

    task automatic flush_frame();
        byte_item_t it;
        foreach (frame[i])
        begin
            it.data = frame[i];
            it.last = (i == frame.size() - 1);
            stim_q.push_back(it);
        end
        frame.delete();
    endtask

    task automatic add_frame(input logic [31:0] word, input int len);
        for (int i = len - 1; i >= 0; i--)
            frame.push_back(word[8*i +: 8]);
        flush_frame();
    endtask

    task automatic put_cp(input logic [20:0] cp, input int len);
        case (len)
            1:
            begin
                frame.push_back({1'b0, cp[6:0]});
            end
            2:
            begin
                frame.push_back({3'b110, cp[10:6]});
                frame.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                frame.push_back({4'b1110, cp[15:12]});
                frame.push_back({2'b10, cp[11:6]});
                frame.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                frame.push_back({5'b11110, cp[20:18]});
                frame.push_back({2'b10, cp[17:12]});
                frame.push_back({2'b10, cp[11:6]});
                frame.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic push_char();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 40)
            put_cp(21'($urandom_range(0, 21'h7F)), 1);
        else if (kind < 60)
            put_cp(21'($urandom_range(21'h80, 21'h7FF)), 2);
        else if (kind < 80)
            put_cp(21'($urandom_range(21'h800, 21'hFFFF)), 3);
        else if (kind < 92)
            put_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
        else if (kind < 95)
            put_cp(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
        else if (kind < 98)
        begin
            // overlong forms
            len = $urandom_range(2, 4);
            if (len == 2)
                put_cp(21'($urandom_range(0, 21'h7F)), 2);
            else if (len == 3)
                put_cp(21'($urandom_range(0, 21'h7FF)), 3);
            else
                put_cp(21'($urandom_range(0, 21'hFFFF)), 4);
        end
        else
            put_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
    endtask

    // sender
    always @(negedge clk)
    begin : feed
        logic       nxt_valid;
        logic [7:0] nxt_data;
        logic       nxt_last;
        byte_item_t it;
        nxt_valid = s_tvalid;
        nxt_data = s_tdata;
        nxt_last = s_tlast;
        if (!rst_n)
        begin
            nxt_valid = 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            nxt_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (stim_q.size() != 0)
            begin
                if (stim_q.size() >= 150 && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 8) - 1;
                else
                begin
                    it = stim_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data = it.data;
                    nxt_last = it.last;
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata <= nxt_data;
        s_tlast <= nxt_last;
    end

    // receiver
    always @(negedge clk)
    begin : drain
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (!rst_n)
            nxt_ready = 1'b0;
        else
        begin
            if (!hold_done && bytes_taken >= 300)
            begin
                hold_done = 1'b1;
                long_hold = 120;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                nxt_ready = 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                nxt_ready = 1'b0;
            end
            else if (stim_q.size() >= 150 && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(1, 8) - 1;
                nxt_ready = 1'b0;
            end
        end
        m_tready <= nxt_ready;
    end

    always @(posedge clk)
    begin : watch
        verdict_t want;
        in_fire = rst_n && s_tvalid && s_tready;
        if (in_fire)
        begin
            bytes_taken++;
            take_byte(s_tdata, s_tlast);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            streams_seen++;
            if (m_tdata[7:0] != 8'h00)
                error_streams++;
            if (m_tdata[40])
                incomplete_streams++;
            if (owed_verdicts.size() == 0)
            begin
                $error("result transfer with no verdict outstanding: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = owed_verdicts.pop_front();
                if (m_tdata[7:0] !== want.flags)
                begin
                    $error("error_flags: expected %h, got %h", want.flags, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[39:8] !== want.pos)
                begin
                    $error("error_position: expected %0d, got %0d", want.pos, m_tdata[39:8]);
                    mismatches++;
                end
                if (m_tdata[40] !== want.incomplete)
                begin
                    $error("incomplete: expected %b, got %b", want.incomplete, m_tdata[40]);
                    mismatches++;
                end
                if (m_tdata[47:41] !== 7'd0)
                begin
                    $error("padding: expected %h, got %h", 7'd0, m_tdata[47:41]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int pick;
        int at;
        logic [7:0] junk;

        add_frame(32'hC3A9, 2);
        add_frame(32'hE282AC, 3);
        add_frame(32'hF09F9880, 4);
        add_frame(32'hC080, 2);
        add_frame(32'hE080, 2);
        add_frame(32'hF080, 2);
        add_frame(32'hEDA080, 3);
        add_frame(32'hF4908080, 4);
        add_frame(32'h80, 1);
        add_frame(32'hE282, 2);
        add_frame(32'hFF, 1);
        add_frame(32'hC341, 2);
        add_frame(32'h00, 1);

        while (stim_q.size() < 1230)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 9)
            begin
                repeat ($urandom_range(1, 10))
                    frame.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    push_char();
                if (pick >= 7)
                begin
                    at = $urandom_range(0, frame.size() - 1);
                    junk = 8'($urandom_range(0, 255));
                    case ($urandom_range(0, 2))
                        0: frame[at] = junk;
                        1: if (frame.size() > 1) frame.delete(frame.size() - 1);
                        default: frame.insert(at, {2'b10, junk[5:0]});
                    endcase
                end
            end
            flush_frame();
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (owed_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d bytes in %0d streams checked;", bytes_taken, streams_seen);
        $display("%0d streams flagged an error, %0d ended mid-sequence",
                 error_streams, incomplete_streams);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
